@@ hdl/assert_macros.svh @@
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define CR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cr_pkg.sv @@
// Types, constants and helper functions of the spline evaluator.
package cr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 6;
  localparam int SEG_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int COUNT_W    = 7;
  localparam int COORD_W    = 32;
  localparam int PT_W       = 3 * COORD_W;
  localparam int MU_W       = 17;
  localparam int TW         = 18;
  localparam int HW         = 42;
  localparam int PROD_W     = 60;
  localparam int MAG_W      = 40;
  localparam int SQ_W       = 30;
  localparam int SUM_W      = 2 * SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_CNT_W = $clog2(ROOT_W);
  localparam int SHIFT_W    = 4;
  localparam int MAGS_W     = ROOT_W + MAG_W - SQ_W;
  localparam int WT_W       = 15;
  localparam int TERM_W     = MAGS_W + WT_W;
  localparam int ACC_W      = 64;
  localparam int LEN_W      = 48;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int NODES      = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;
  localparam logic               REG_POINT_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EVAL  = 2'd1,
    ACT_LEN   = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_READ,
    ST_COEF,
    ST_HINIT,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_NORM,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_WACC,
    ST_TOTAL
  } st_e;

  function automatic logic [15:0] node_t(input logic [2:0] i);
    logic [15:0] r;
    case (i)
      3'd0:    r = 16'd3074;
      3'd1:    r = 16'd15123;
      3'd2:    r = 16'd32768;
      3'd3:    r = 16'd50413;
      3'd4:    r = 16'd62462;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [WT_W-1:0] half_w(input logic [2:0] i);
    logic [WT_W-1:0] r;
    case (i)
      3'd0, 3'd4: r = 15'd7764;
      3'd1, 3'd3: r = 15'd15684;
      3'd2:       r = 15'd18641;
      default:    r = 15'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [HW-1:0] sx(input logic [COORD_W-1:0] v);
    return {{(HW - COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

@@ hdl/cr_stream_if.sv @@
// Valid/ready channel interfaces for request and result items.
interface cr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [cr_pkg::IDX_W-1:0]             index;
  logic signed [cr_pkg::COORD_W-1:0]    coord_x;
  logic signed [cr_pkg::COORD_W-1:0]    coord_y;
  logic signed [cr_pkg::COORD_W-1:0]    coord_z;
  logic [cr_pkg::MU_W-1:0]              mu;

  modport source (output valid, action, index, coord_x, coord_y, coord_z, mu, input ready);
  modport sink (input valid, action, index, coord_x, coord_y, coord_z, mu, output ready);
endinterface

interface cr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cr_pkg::COORD_W-1:0]    out_x;
  logic signed [cr_pkg::COORD_W-1:0]    out_y;
  logic signed [cr_pkg::COORD_W-1:0]    out_z;
  logic [cr_pkg::LEN_W-1:0]             total_length;
  logic                                 status;

  modport source (output valid, out_x, out_y, out_z, total_length, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, total_length, status, output ready);
endinterface

@@ hdl/cr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module cr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/cr_sqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
module cr_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cr_pkg::SUM_W-1:0]  rad_i,
  output logic                      done_o,
  output logic [cr_pkg::ROOT_W-1:0] root_o
);

  localparam int REM_W = cr_pkg::ROOT_W + 4;

  logic [cr_pkg::SUM_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic [cr_pkg::ROOT_W-1:0]     root_q, root_d;
  logic [cr_pkg::SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [REM_W-1:0]              rem_sh;
  logic [REM_W-1:0]              trial;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[cr_pkg::SUM_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[cr_pkg::SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[cr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[cr_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cr_pkg::SQRT_CNT_W'(cr_pkg::ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/catmull_rom_spline_evaluator_core.sv @@
// Top level of the Catmull-Rom spline evaluator: sequencer, datapath and point store.
//
//  channel | direction | handshake            | payload
//  in_i    | in        | valid/ready          | action, index, coord_x/y/z, mu
//  out_o   | out       | valid/ready          | out_x/y/z, total_length, status
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// A write item goes straight to the response; an evaluate item makes four store reads,
// then a shared multiplier runs the Horner chain axis by axis, unless a special case
// answers from a stored point. A length item runs the chain at each node of each segment.
// Reset sets point_count to 2; the point store holds no reset value.
// One item is in work at a time; the result register frees the sequencer while it waits.
`include "assert_macros.svh"

module catmull_rom_spline_evaluator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cr_in_if.sink                       in_i,
  cr_out_if.source                    out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cr_pkg::APB_AW-1:0]   paddr,
  input  logic [cr_pkg::APB_DW-1:0]   pwdata,
  output logic [cr_pkg::APB_DW-1:0]   prdata,
  output logic                        pready
);

  cr_pkg::st_e state_q, state_d;

  logic [cr_pkg::COUNT_W-1:0] pc_q;
  logic [cr_pkg::CNT_W-1:0]   n_act;
  logic [cr_pkg::CNT_W-1:0]   nseg;

  logic                       in_acc;
  logic                       out_free;
  logic                       out_valid_q;

  logic [1:0]                 act_q;
  logic [cr_pkg::SEG_W-1:0]   seg_q;
  logic [cr_pkg::MU_W-1:0]    mu_q;
  logic [15:0]                t_q;
  logic [2:0]                 rd_cnt_q;
  logic [1:0]                 axis_q;
  logic [1:0]                 step_q;
  logic [2:0]                 node_q;
  logic [1:0]                 sq_cnt_q;
  logic [cr_pkg::SHIFT_W-1:0] s_q;

  logic [cr_pkg::PT_W-1:0]    pt_q [4];
  logic signed [cr_pkg::HW-1:0] c1_q [3];
  logic signed [cr_pkg::HW-1:0] c2_q [3];
  logic signed [cr_pkg::HW-1:0] c3_q [3];
  logic signed [cr_pkg::HW-1:0] p2_q [3];
  logic signed [cr_pkg::HW-1:0] h_q;
  logic signed [cr_pkg::PROD_W-1:0] prod_q;
  logic [cr_pkg::MAG_W-1:0]   a_q [3];
  logic [cr_pkg::SUM_W-1:0]   sum_q;
  logic [cr_pkg::TERM_W-1:0]  term_q;
  logic [cr_pkg::ACC_W-1:0]   acc_q;

  logic signed [cr_pkg::COORD_W-1:0] res_q [3];
  logic [cr_pkg::LEN_W-1:0]   res_len_q;
  logic                       res_status_q;

  logic signed [cr_pkg::COORD_W-1:0] ox_q, oy_q, oz_q;
  logic [cr_pkg::LEN_W-1:0]   olen_q;
  logic                       ostat_q;

  logic                       ram_we;
  logic [cr_pkg::ADDR_W-1:0]  ram_waddr;
  logic [cr_pkg::ADDR_W-1:0]  ram_raddr;
  logic [cr_pkg::PT_W-1:0]    ram_rdata;
  logic [cr_pkg::SEG_W-1:0]   idx_ext;
  logic [cr_pkg::SEG_W:0]     rd_full;

  logic                       is_deriv;
  logic                       seg_hi;
  logic                       seg_first;
  logic                       seg_last;
  logic                       eval_special;

  logic signed [cr_pkg::HW-1:0] c1_c [3];
  logic signed [cr_pkg::HW-1:0] c2_c [3];
  logic signed [cr_pkg::HW-1:0] c3_c [3];
  logic signed [cr_pkg::HW-1:0] p2_c [3];

  logic signed [cr_pkg::HW-1:0] h_init;
  logic signed [cr_pkg::HW-1:0] h_term;
  logic signed [cr_pkg::HW-1:0] h_next;
  logic signed [cr_pkg::HW-1:0] d_val;
  logic signed [cr_pkg::HW-1:0] d_abs;
  logic signed [cr_pkg::PROD_W-1:0] prod_rnd;
  logic signed [cr_pkg::TW-1:0] t_s;
  logic [1:0]                 last_step;

  logic [cr_pkg::MAG_W-1:0]   a_max;
  logic [cr_pkg::SHIFT_W-1:0] s_c;
  logic [cr_pkg::MAG_W-1:0]   a_sh;
  logic [cr_pkg::SQ_W-1:0]    sq_in;

  logic                       root_start;
  logic                       root_done;
  logic [cr_pkg::ROOT_W-1:0]  root;
  logic [cr_pkg::MAGS_W-1:0]  mag;

  logic [cr_pkg::ACC_W:0]     acc_sum;
  logic [cr_pkg::LEN_W:0]     len_full;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cr_pkg::REG_POINT_COUNT)
                ? {{(cr_pkg::APB_DW - cr_pkg::COUNT_W){1'b0}}, pc_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cr_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == cr_pkg::REG_POINT_COUNT)) begin
      pc_q <= pwdata[cr_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    if (pc_q < 7'd2) begin
      n_act = cr_pkg::CNT_W'(2);
    end else if (32'(pc_q) > 32'(cr_pkg::MAX_POINTS)) begin
      n_act = cr_pkg::CNT_W'(cr_pkg::MAX_POINTS);
    end else begin
      n_act = cr_pkg::CNT_W'(pc_q);
    end
    nseg = n_act - 1'b1;
  end

  // Handshakes.
  assign in_i.ready = (state_q == cr_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Point store, one entry of x, y and z per point.
  assign idx_ext   = cr_pkg::SEG_W'(in_i.index);
  assign ram_we    = in_acc && (in_i.action == cr_pkg::ACT_WRITE)
                   && (idx_ext < cr_pkg::SEG_W'(n_act));
  assign ram_waddr = idx_ext[cr_pkg::ADDR_W-1:0];

  assign is_deriv  = (act_q == cr_pkg::ACT_LEN);
  assign seg_hi    = seg_q >= cr_pkg::SEG_W'(nseg);
  assign seg_first = (seg_q == '0);
  assign seg_last  = ({1'b0, seg_q} + 1'b1) == (cr_pkg::SEG_W + 1)'(nseg);
  assign eval_special = seg_hi || (mu_q == '0) || mu_q[cr_pkg::MU_W-1];

  always_comb begin
    case (rd_cnt_q)
      3'd0:    rd_full = {1'b0, seg_q} - 1'b1;
      3'd1:    rd_full = (!is_deriv && seg_hi) ? (cr_pkg::SEG_W + 1)'(nseg)
                                               : {1'b0, seg_q};
      3'd2:    rd_full = {1'b0, seg_q} + 1'b1;
      default: rd_full = {1'b0, seg_q} + 2'd2;
    endcase
    ram_raddr = rd_full[cr_pkg::ADDR_W-1:0];
  end

  cr_ram #(
    .WIDTH(cr_pkg::PT_W),
    .DEPTH(cr_pkg::MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_i.coord_z, in_i.coord_y, in_i.coord_x}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Segment coefficients for all three axes.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [cr_pkg::HW-1:0] s0, p0, p1, s3, e0, e1;
      s0 = cr_pkg::sx(pt_q[0][a*cr_pkg::COORD_W +: cr_pkg::COORD_W]);
      p0 = cr_pkg::sx(pt_q[1][a*cr_pkg::COORD_W +: cr_pkg::COORD_W]);
      p1 = cr_pkg::sx(pt_q[2][a*cr_pkg::COORD_W +: cr_pkg::COORD_W]);
      s3 = cr_pkg::sx(pt_q[3][a*cr_pkg::COORD_W +: cr_pkg::COORD_W]);
      e0 = seg_first ? (p0 <<< 1) - p1 : s0;
      e1 = seg_last ? (p1 <<< 1) - p0 : s3;
      c1_c[a] = p1 - e0;
      c2_c[a] = (e0 <<< 1) - ((p0 <<< 2) + p0) + (p1 <<< 2) - e1;
      c3_c[a] = ((p0 <<< 1) + p0) - ((p1 <<< 1) + p1) - e0 + e1;
      p2_c[a] = p0 <<< 1;
    end
  end

  // Horner step on the shared multiplier.
  assign t_s       = $signed({2'b00, t_q});
  assign last_step = is_deriv ? 2'd1 : 2'd2;
  assign prod_rnd  = prod_q + cr_pkg::PROD_W'(32768);
  assign h_init    = is_deriv ? ((c3_q[axis_q] <<< 1) + c3_q[axis_q]) : c3_q[axis_q];

  always_comb begin
    case (step_q)
      2'd0:    h_term = is_deriv ? (c2_q[axis_q] <<< 1) : c2_q[axis_q];
      2'd1:    h_term = c1_q[axis_q];
      default: h_term = p2_q[axis_q];
    endcase
    h_next = h_term + prod_rnd[cr_pkg::HW+15:16];
    d_val  = (h_q + cr_pkg::HW'(1)) >>> 1;
    d_abs  = d_val[cr_pkg::HW-1] ? -d_val : d_val;
  end

  // Normalizing shift of the derivative magnitudes.
  always_comb begin
    a_max = a_q[0];
    if (a_q[1] > a_max) begin
      a_max = a_q[1];
    end
    if (a_q[2] > a_max) begin
      a_max = a_q[2];
    end
    s_c = '0;
    for (int b = cr_pkg::SQ_W; b < cr_pkg::MAG_W; b++) begin
      if (a_max[b]) begin
        s_c = cr_pkg::SHIFT_W'(b - cr_pkg::SQ_W + 1);
      end
    end
    a_sh  = a_q[sq_cnt_q] >> s_q;
    sq_in = a_sh[cr_pkg::SQ_W-1:0];
  end

  assign root_start = (state_q == cr_pkg::ST_ROOT_GO);

  cr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (sum_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign mag      = cr_pkg::MAGS_W'(root) << s_q;
  assign acc_sum  = {1'b0, acc_q} + (cr_pkg::ACC_W + 1)'(term_q);
  assign len_full = {1'b0, acc_q[cr_pkg::ACC_W-1:16]} + (cr_pkg::LEN_W + 1)'(acc_q[15]);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_i.action)
            cr_pkg::ACT_EVAL, cr_pkg::ACT_LEN: state_d = cr_pkg::ST_READ;
            default:                           state_d = cr_pkg::ST_RESP;
          endcase
        end
      end
      cr_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = cr_pkg::ST_IDLE;
        end
      end
      cr_pkg::ST_READ: begin
        if (rd_cnt_q == 3'd4) begin
          state_d = cr_pkg::ST_COEF;
        end
      end
      cr_pkg::ST_COEF: begin
        state_d = (!is_deriv && eval_special) ? cr_pkg::ST_RESP : cr_pkg::ST_HINIT;
      end
      cr_pkg::ST_HINIT: state_d = cr_pkg::ST_MUL;
      cr_pkg::ST_MUL:   state_d = cr_pkg::ST_ACC;
      cr_pkg::ST_ACC: begin
        state_d = (step_q == last_step) ? cr_pkg::ST_FIN : cr_pkg::ST_MUL;
      end
      cr_pkg::ST_FIN: begin
        if (axis_q == 2'd2) begin
          state_d = is_deriv ? cr_pkg::ST_NORM : cr_pkg::ST_RESP;
        end else begin
          state_d = cr_pkg::ST_HINIT;
        end
      end
      cr_pkg::ST_NORM: state_d = cr_pkg::ST_SQ;
      cr_pkg::ST_SQ: begin
        if (sq_cnt_q == 2'd2) begin
          state_d = cr_pkg::ST_ROOT_GO;
        end
      end
      cr_pkg::ST_ROOT_GO: state_d = cr_pkg::ST_ROOT_WAIT;
      cr_pkg::ST_ROOT_WAIT: begin
        if (root_done) begin
          state_d = cr_pkg::ST_WACC;
        end
      end
      cr_pkg::ST_WACC: begin
        if (node_q == 3'(cr_pkg::NODES - 1)) begin
          state_d = seg_last ? cr_pkg::ST_TOTAL : cr_pkg::ST_READ;
        end else begin
          state_d = cr_pkg::ST_HINIT;
        end
      end
      cr_pkg::ST_TOTAL: state_d = cr_pkg::ST_RESP;
      default:          state_d = cr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cr_pkg::ST_IDLE: begin
        act_q        <= in_i.action;
        seg_q        <= (in_i.action == cr_pkg::ACT_LEN) ? '0 : idx_ext;
        mu_q         <= in_i.mu;
        t_q          <= (in_i.action == cr_pkg::ACT_LEN) ? cr_pkg::node_t(3'd0)
                                                         : in_i.mu[15:0];
        rd_cnt_q     <= '0;
        axis_q       <= '0;
        step_q       <= '0;
        node_q       <= '0;
        acc_q        <= '0;
        res_q[0]     <= '0;
        res_q[1]     <= '0;
        res_q[2]     <= '0;
        res_len_q    <= '0;
        res_status_q <= (in_i.action == cr_pkg::ACT_WRITE)
                     && (idx_ext >= cr_pkg::SEG_W'(n_act));
      end
      cr_pkg::ST_READ: begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
        if (rd_cnt_q != 3'd0) begin
          pt_q[2'(rd_cnt_q - 1'b1)] <= ram_rdata;
        end
      end
      cr_pkg::ST_COEF: begin
        for (int a = 0; a < 3; a++) begin
          c1_q[a] <= c1_c[a];
          c2_q[a] <= c2_c[a];
          c3_q[a] <= c3_c[a];
          p2_q[a] <= p2_c[a];
          if (!is_deriv) begin
            res_q[a] <= (seg_hi || (mu_q == '0))
                      ? pt_q[1][a*cr_pkg::COORD_W +: cr_pkg::COORD_W]
                      : pt_q[2][a*cr_pkg::COORD_W +: cr_pkg::COORD_W];
          end
        end
        axis_q <= '0;
        step_q <= '0;
      end
      cr_pkg::ST_HINIT: begin
        h_q    <= h_init;
        step_q <= '0;
      end
      cr_pkg::ST_MUL: begin
        prod_q <= h_q * t_s;
      end
      cr_pkg::ST_ACC: begin
        h_q    <= h_next;
        step_q <= step_q + 1'b1;
      end
      cr_pkg::ST_FIN: begin
        if (is_deriv) begin
          a_q[axis_q] <= d_abs[cr_pkg::MAG_W-1:0];
        end else if (d_val > cr_pkg::HW'(32'sh7FFF_FFFF)) begin
          res_q[axis_q] <= 32'sh7FFF_FFFF;
        end else if (d_val < -cr_pkg::HW'(33'sh0_8000_0000)) begin
          res_q[axis_q] <= 32'sh8000_0000;
        end else begin
          res_q[axis_q] <= d_val[cr_pkg::COORD_W-1:0];
        end
        axis_q <= axis_q + 1'b1;
      end
      cr_pkg::ST_NORM: begin
        s_q      <= s_c;
        sum_q    <= '0;
        sq_cnt_q <= '0;
      end
      cr_pkg::ST_SQ: begin
        sum_q    <= sum_q + cr_pkg::SUM_W'(sq_in) * cr_pkg::SUM_W'(sq_in);
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      cr_pkg::ST_ROOT_WAIT: begin
        term_q <= cr_pkg::TERM_W'(mag) * cr_pkg::TERM_W'(cr_pkg::half_w(node_q));
      end
      cr_pkg::ST_WACC: begin
        acc_q  <= acc_sum[cr_pkg::ACC_W] ? '1 : acc_sum[cr_pkg::ACC_W-1:0];
        axis_q <= '0;
        if (node_q == 3'(cr_pkg::NODES - 1)) begin
          node_q   <= '0;
          t_q      <= cr_pkg::node_t(3'd0);
          seg_q    <= seg_q + 1'b1;
          rd_cnt_q <= '0;
        end else begin
          node_q <= node_q + 1'b1;
          t_q    <= cr_pkg::node_t(node_q + 1'b1);
        end
      end
      cr_pkg::ST_TOTAL: begin
        res_len_q <= len_full[cr_pkg::LEN_W] ? '1 : len_full[cr_pkg::LEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == cr_pkg::ST_RESP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == cr_pkg::ST_RESP) && out_free) begin
      ox_q    <= res_q[0];
      oy_q    <= res_q[1];
      oz_q    <= res_q[2];
      olen_q  <= res_len_q;
      ostat_q <= res_status_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = ox_q;
  assign out_o.out_y        = oy_q;
  assign out_o.out_z        = oz_q;
  assign out_o.total_length = olen_q;
  assign out_o.status       = ostat_q;

  `CR_ASSERT_NEXT(a_accept_starts_work, in_acc, state_q != cr_pkg::ST_IDLE, "Item accepted but sequencer stayed idle")
  `CR_ASSERT_NEXT(a_resp_loads_result, (state_q == cr_pkg::ST_RESP) && out_free, out_valid_q, "Result not presented after response")
  `CR_ASSERT(a_count_in_range, (n_act >= cr_pkg::CNT_W'(2)) && (32'(n_act) <= 32'(cr_pkg::MAX_POINTS)), "Active point count out of range")
  `CR_ASSERT(a_root_only_in_length, root_start |-> is_deriv, "Square root started outside a length item")

endmodule
